FILE: hw/rtl/ecl_pkg.sv
`default_nettype none

package ecl_pkg;

    localparam int CHAR_W = 21;
    localparam int CLASS_W = 3;
    localparam int SLOTS = 3;

    localparam logic [CLASS_W-1:0] CLS_WORD = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_OP = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_BREAK = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_QUOTE = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_END = 3'd4;

    localparam logic [CHAR_W-1:0] CH_LT = 21'h3C;
    localparam logic [CHAR_W-1:0] CH_GT = 21'h3E;
    localparam logic [CHAR_W-1:0] CH_EQ = 21'h3D;
    localparam logic [CHAR_W-1:0] CH_BANG = 21'h21;
    localparam logic [CHAR_W-1:0] CH_HASH = 21'h23;
    localparam logic [CHAR_W-1:0] CH_LF = 21'h0A;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 21'h22;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 21'h5C;
    localparam logic [CHAR_W-1:0] CH_SPACE = 21'h20;
    localparam logic [CHAR_W-1:0] CH_TAB = 21'h09;
    localparam logic [CHAR_W-1:0] CH_VT = 21'h0B;
    localparam logic [CHAR_W-1:0] CH_FF = 21'h0C;
    localparam logic [CHAR_W-1:0] CH_CR = 21'h0D;
    localparam logic [CHAR_W-1:0] CH_PLUS = 21'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 21'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR = 21'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 21'h2F;
    localparam logic [CHAR_W-1:0] CH_AMP = 21'h26;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 21'h28;
    localparam logic [CHAR_W-1:0] CH_LBRACK = 21'h5B;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 21'h7B;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 21'h29;
    localparam logic [CHAR_W-1:0] CH_RBRACK = 21'h5D;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 21'h7D;

    typedef struct packed {
        logic [CHAR_W-1:0]  token_char;
        logic               token_start;
        logic [CLASS_W-1:0] token_class;
        logic               last_of_run;
    } t_result;

    // All results caused by one input transfer, in delivery order from slot 0.
    typedef struct packed {
        t_result [SLOTS-1:0] slots;
        logic [1:0]          count;
    } t_bundle;

endpackage

`default_nettype wire

FILE: hw/rtl/expression_char_lexer.sv
// The first result of a character is offered in the cycle after its input transfer.
// Throughput: one character per cycle while each causes at most one result and the output
// accepts it; a character causing n results (n up to 3) holds the input side until the
// single output register, draining one accepted result per cycle, holds only its last.
// Reset (i_rst_n low, synchronous) returns scanning to normal mode and discards results.
`default_nettype none

module expression_char_lexer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,  // [20:0] character, [23:21] zero
    input  wire logic        i_s_tlast,  // text_end
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,  // [20:0] token_char, [23:21] zero
    output logic [3:0]       o_m_tuser,  // [0] token_start, [3:1] token_class
    output logic             o_m_tlast   // last_of_run
);
    import ecl_pkg::*;

    t_bundle w_bundle;
    t_result w_result;
    logic    w_ready;
    logic    w_fire;

    assign o_s_tready = w_ready;
    assign w_fire = i_s_tvalid && w_ready;

    ecl_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_char     (i_s_tdata[CHAR_W-1:0]),
        .i_text_end (i_s_tlast),
        .o_bundle   (w_bundle)
    );

    ecl_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_fire),
        .i_bundle (w_bundle),
        .o_ready  (w_ready),
        .o_valid  (o_m_tvalid),
        .i_taken  (i_m_tready),
        .o_result (w_result)
    );

    assign o_m_tdata = {3'b000, w_result.token_char};
    assign o_m_tuser = {w_result.token_class, w_result.token_start};
    assign o_m_tlast = w_result.last_of_run;

endmodule

`default_nettype wire

FILE: hw/rtl/ecl_scan.sv
`default_nettype none

module ecl_scan (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_fire,
    input  wire logic [ecl_pkg::CHAR_W-1:0] i_char,
    input  wire logic                  i_text_end,
    output ecl_pkg::t_bundle           o_bundle
);
    import ecl_pkg::*;

    typedef enum logic [3:0] {
        MODE_NORMAL  = 4'b0001,
        MODE_COMMENT = 4'b0010,
        MODE_QUOTE   = 4'b0100,
        MODE_ESCAPE  = 4'b1000
    } t_mode;

    typedef enum logic [2:0] {
        HELD_NONE = 3'd0,
        HELD_LT   = 3'd1,
        HELD_GT   = 3'd2,
        HELD_EQ   = 3'd3,
        HELD_BANG = 3'd4
    } t_held;

    t_mode r_mode, n_mode;
    t_held r_held, n_held;
    logic  r_inw, n_inw;

    function automatic t_bundle put(t_bundle b, logic [CHAR_W-1:0] ch, logic start,
                                    logic [CLASS_W-1:0] cls);
        t_bundle r;
        r = b;
        if (r.count != 2'd3) begin
            r.slots[r.count].token_char = ch;
            r.slots[r.count].token_start = start;
            r.slots[r.count].token_class = cls;
            r.slots[r.count].last_of_run = 1'b0;
            r.count = r.count + 2'd1;
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] held_char(t_held h);
        logic [CHAR_W-1:0] c;
        c = '0;
        unique case (h)
            HELD_LT:   c = CH_LT;
            HELD_GT:   c = CH_GT;
            HELD_EQ:   c = CH_EQ;
            HELD_BANG: c = CH_BANG;
            default:   c = '0;
        endcase
        return c;
    endfunction

    always_comb begin
        t_bundle b;
        logic    consumed;
        b = '0;
        consumed = 1'b0;
        n_mode = r_mode;
        n_held = r_held;
        n_inw = r_inw;

        // A held candidate is settled first: completed by '=' or released alone.
        if (r_mode == MODE_NORMAL && r_held != HELD_NONE) begin
            if (i_char == CH_EQ) begin
                b = put(b, held_char(r_held), 1'b1, CLS_OP);
                b = put(b, CH_EQ, 1'b0, CLS_OP);
                n_inw = 1'b0;
                consumed = 1'b1;
            end else if (r_held == HELD_EQ) begin
                b = put(b, CH_EQ, !r_inw, CLS_WORD);
                n_inw = 1'b1;
            end else begin
                b = put(b, held_char(r_held), 1'b1, CLS_OP);
                n_inw = 1'b0;
            end
            n_held = HELD_NONE;
        end

        if (!consumed) begin
            unique case (r_mode)
                MODE_NORMAL: begin
                    case (i_char)
                        CH_LT: n_held = HELD_LT;
                        CH_GT: n_held = HELD_GT;
                        CH_EQ: n_held = HELD_EQ;
                        CH_BANG: n_held = HELD_BANG;
                        CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_BSLASH, CH_AMP,
                        CH_LPAREN, CH_LBRACK, CH_LBRACE, CH_RPAREN, CH_RBRACK,
                        CH_RBRACE: begin
                            b = put(b, i_char, 1'b1, CLS_OP);
                            n_inw = 1'b0;
                        end
                        CH_LF: begin
                            b = put(b, i_char, 1'b1, CLS_BREAK);
                            n_inw = 1'b0;
                        end
                        CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR: n_inw = 1'b0;
                        CH_HASH: begin
                            n_mode = MODE_COMMENT;
                            n_inw = 1'b0;
                        end
                        CH_DQUOTE: begin
                            b = put(b, i_char, 1'b1, CLS_QUOTE);
                            n_mode = MODE_QUOTE;
                            n_inw = 1'b0;
                        end
                        default: begin
                            b = put(b, i_char, !n_inw, CLS_WORD);
                            n_inw = 1'b1;
                        end
                    endcase
                end
                MODE_COMMENT: begin
                    if (i_char == CH_LF) n_mode = MODE_NORMAL;
                end
                MODE_QUOTE: begin
                    b = put(b, i_char, 1'b0, CLS_QUOTE);
                    if (i_char == CH_BSLASH) n_mode = MODE_ESCAPE;
                    else if (i_char == CH_DQUOTE) n_mode = MODE_NORMAL;
                end
                MODE_ESCAPE: begin
                    b = put(b, i_char, 1'b0, CLS_QUOTE);
                    n_mode = MODE_QUOTE;
                end
                default: n_mode = MODE_NORMAL;
            endcase
        end

        if (i_text_end) begin
            if (n_held == HELD_EQ) begin
                b = put(b, CH_EQ, !n_inw, CLS_WORD);
            end else if (n_held != HELD_NONE) begin
                b = put(b, held_char(n_held), 1'b1, CLS_OP);
            end
            b = put(b, '0, 1'b1, CLS_END);
            n_mode = MODE_NORMAL;
            n_held = HELD_NONE;
            n_inw = 1'b0;
        end

        for (int i = 0; i < SLOTS; i++) begin
            b.slots[i].last_of_run = (b.count == 2'(i + 1));
        end
        o_bundle = b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_held <= HELD_NONE;
            r_inw <= 1'b0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_held <= n_held;
            r_inw <= n_inw;
        end
    end

`ifndef SYNTHESIS
    a_held_only_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held != HELD_NONE) |-> (r_mode == MODE_NORMAL))
        else $error("operator held outside normal scanning");
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_text_end) |=> (r_mode == MODE_NORMAL && r_held == HELD_NONE && !r_inw))
        else $error("state not cleared after end of text");
    a_end_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_text_end) |-> (o_bundle.count != 2'd0))
        else $error("end of text without end marker");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/ecl_out.sv
`default_nettype none

module ecl_out (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  ecl_pkg::t_bundle      i_bundle,
    output logic                  o_ready,
    output logic                  o_valid,
    input  wire logic             i_taken,
    output ecl_pkg::t_result      o_result
);
    import ecl_pkg::*;

    t_result [SLOTS-1:0] r_slots;
    logic [1:0]          r_cnt;
    logic [1:0]          r_pos;

    // A new bundle may load while the final pending result transfers.
    assign o_ready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_taken);
    assign o_valid = (r_cnt != 2'd0);
    assign o_result = r_slots[r_pos];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slots <= i_bundle.slots;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_pos <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_bundle.count;
            r_pos <= 2'd0;
        end else if (o_valid && i_taken) begin
            r_cnt <= r_cnt - 2'd1;
            r_pos <= r_pos + 2'd1;
        end
    end

`ifndef SYNTHESIS
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_pos} + {1'b0, r_cnt}) <= 3'd3)
        else $error("result index beyond bundle");
    a_last_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) |-> o_result.last_of_run)
        else $error("final result of a bundle not marked last");
    a_no_early_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > 2'd1) |-> !o_result.last_of_run)
        else $error("result marked last with more pending");
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_taken) |=> $stable(r_pos) && $stable(r_cnt))
        else $error("pending results moved while stalled");
`endif

endmodule

`default_nettype wire
